[rtl/core/indexed_char_list_store_unit_assert.svh]
// Assertion macros shared by the RTL.
`ifndef INDEXED_CHAR_LIST_STORE_UNIT_ASSERT_SVH
`define INDEXED_CHAR_LIST_STORE_UNIT_ASSERT_SVH

// Checked only while out of reset.
`define ICLS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define ICLS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[rtl/core/icls_pkg.sv]
package icls_pkg;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned LEN_W    = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W    = LEN_W + 1;

  localparam logic [7:0] SPACE_CHAR = 8'h20;

  typedef enum logic [2:0] {
    CMD_READ    = 3'd0,
    CMD_WRITE   = 3'd1,
    CMD_DELETE  = 3'd2,
    CMD_FIND    = 3'd3,
    CMD_RESTART = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_RDATA,
    ST_DPREP,
    ST_SHIFT,
    ST_SCAN,
    ST_DONE
  } state_e;

  // Request from sequencer to the character store
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [7:0]       wdata;
    logic [IDX_W-1:0] raddr;
    logic             clr;
  } store_req_t;

endpackage

[rtl/core/icls_if.sv]
interface icls_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic [6:0] position;
  logic [7:0] char_value;

  modport source (output valid, output command, output position, output char_value,
                  input ready);
  modport sink   (input valid, input command, input position, input char_value,
                  output ready);
endinterface

interface icls_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_value;
  logic [5:0] found_position;
  logic       status;

  modport source (output valid, output read_value, output found_position,
                  output status, input ready);
  modport sink   (input valid, input read_value, input found_position,
                  input status, output ready);
endinterface

[rtl/core/icls_store.sv]
module icls_store (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  icls_pkg::store_req_t req_i,
  output logic [7:0]           rdata_o
);
  import icls_pkg::*;

  logic [7:0]          mem_q [CAPACITY];
  logic [CAPACITY-1:0] vld_q;
  logic [7:0]          raw_q;
  logic                rvld_q;

  // entry not yet written since reset/restart reads as space
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (req_i.clr) begin
      vld_q <= '0;
    end else if (req_i.we) begin
      vld_q[req_i.waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    raw_q  <= mem_q[req_i.raddr];
    rvld_q <= vld_q[req_i.raddr];
  end

  assign rdata_o = rvld_q ? raw_q : SPACE_CHAR;

endmodule

[rtl/core/icls_seq.sv]
`include "indexed_char_list_store_unit_assert.svh"

module icls_seq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cmd_valid_i,
  output logic                 cmd_ready_o,
  input  logic [2:0]           cmd_command_i,
  input  logic [6:0]           cmd_position_i,
  input  logic [7:0]           cmd_char_value_i,
  output logic                 res_valid_o,
  input  logic                 res_ready_i,
  output logic [7:0]           res_read_value_o,
  output logic [5:0]           res_found_position_o,
  output logic                 res_status_o,
  output icls_pkg::store_req_t req_o,
  input  logic [7:0]           rdata_i
);
  import icls_pkg::*;

  state_e           st_q, st_d;
  cmd_e             cmd_q, cmd_d;
  logic [6:0]       pos_q, pos_d;
  logic [7:0]       val_q, val_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [7:0]       rs_rd_q, rs_rd_d;
  logic [5:0]       rs_fp_q, rs_fp_d;
  logic             rs_st_q, rs_st_d;
  logic             out_vld_q, out_vld_d;
  logic [7:0]       out_rd_q, out_rd_d;
  logic [5:0]       out_fp_q, out_fp_d;
  logic             out_st_q, out_st_d;

  // shared compare unit
  logic [CMP_W-1:0] cmp_a, cmp_b;
  logic             cmp_lt;
  logic [CMP_W-1:0] idx_ext, len_ext;

  assign cmp_lt  = cmp_a < cmp_b;
  assign idx_ext = {{(CMP_W-IDX_W){1'b0}}, idx_q};
  assign len_ext = {1'b0, len_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_IDLE;
      len_q     <= LEN_W'(CAPACITY);
      out_vld_q <= 1'b0;
    end else begin
      st_q      <= st_d;
      len_q     <= len_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    pos_q    <= pos_d;
    val_q    <= val_d;
    idx_q    <= idx_d;
    rs_rd_q  <= rs_rd_d;
    rs_fp_q  <= rs_fp_d;
    rs_st_q  <= rs_st_d;
    out_rd_q <= out_rd_d;
    out_fp_q <= out_fp_d;
    out_st_q <= out_st_d;
  end

  always_comb begin
    st_d      = st_q;
    cmd_d     = cmd_q;
    pos_d     = pos_q;
    val_d     = val_q;
    len_d     = len_q;
    idx_d     = idx_q;
    rs_rd_d   = rs_rd_q;
    rs_fp_d   = rs_fp_q;
    rs_st_d   = rs_st_q;
    out_vld_d = out_vld_q;
    out_rd_d  = out_rd_q;
    out_fp_d  = out_fp_q;
    out_st_d  = out_st_q;
    req_o     = '0;
    cmp_a     = '0;
    cmp_b     = '0;
    cmd_ready_o = 1'b0;

    if (res_ready_i) begin
      out_vld_d = 1'b0;
    end

    unique case (st_q)
      ST_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          cmd_d = cmd_e'(cmd_command_i);
          pos_d = cmd_position_i;
          val_d = cmd_char_value_i;
          st_d  = ST_ISSUE;
        end
      end

      ST_ISSUE: begin
        rs_rd_d = '0;
        rs_fp_d = '0;
        rs_st_d = 1'b0;
        st_d    = ST_DONE;
        cmp_a   = {1'b0, pos_q};
        cmp_b   = len_ext;
        unique case (cmd_q)
          CMD_READ: begin
            if (cmp_lt) begin
              req_o.raddr = pos_q[IDX_W-1:0];
              st_d        = ST_RDATA;
            end else begin
              rs_st_d = 1'b1;
            end
          end
          CMD_WRITE: begin
            if (cmp_lt) begin
              req_o.we    = 1'b1;
              req_o.waddr = pos_q[IDX_W-1:0];
              req_o.wdata = val_q;
            end else begin
              rs_st_d = 1'b1;
            end
          end
          CMD_DELETE: begin
            if (cmp_lt) begin
              idx_d = pos_q[IDX_W-1:0];
              st_d  = ST_DPREP;
            end else begin
              rs_st_d = 1'b1;
            end
          end
          CMD_FIND: begin
            cmp_a = '0;
            if (cmp_lt) begin
              req_o.raddr = '0;
              idx_d       = '0;
              st_d        = ST_SCAN;
            end else begin
              rs_st_d = 1'b1;
            end
          end
          CMD_RESTART: begin
            // saturate new length at capacity
            cmp_a     = CMP_W'(CAPACITY);
            cmp_b     = {1'b0, pos_q};
            req_o.clr = 1'b1;
            len_d     = cmp_lt ? LEN_W'(CAPACITY) : LEN_W'(pos_q);
          end
          default: begin
          end
        endcase
      end

      ST_RDATA: begin
        rs_rd_d = rdata_i;
        st_d    = ST_DONE;
      end

      ST_DPREP: begin
        cmp_a = idx_ext + CMP_W'(1);
        cmp_b = len_ext;
        if (cmp_lt) begin
          req_o.raddr = idx_q + IDX_W'(1);
          st_d        = ST_SHIFT;
        end else begin
          len_d = len_q - LEN_W'(1);
          st_d  = ST_DONE;
        end
      end

      ST_SHIFT: begin
        // rdata holds entry idx+1, move it down
        req_o.we    = 1'b1;
        req_o.waddr = idx_q;
        req_o.wdata = rdata_i;
        cmp_a       = idx_ext + CMP_W'(2);
        cmp_b       = len_ext;
        if (cmp_lt) begin
          req_o.raddr = idx_q + IDX_W'(2);
          idx_d       = idx_q + IDX_W'(1);
        end else begin
          len_d = len_q - LEN_W'(1);
          st_d  = ST_DONE;
        end
      end

      ST_SCAN: begin
        cmp_a = idx_ext + CMP_W'(1);
        cmp_b = len_ext;
        if (rdata_i == val_q) begin
          rs_fp_d = 6'(idx_q);
          st_d    = ST_DONE;
        end else if (cmp_lt) begin
          req_o.raddr = idx_q + IDX_W'(1);
          idx_d       = idx_q + IDX_W'(1);
        end else begin
          rs_st_d = 1'b1;
          st_d    = ST_DONE;
        end
      end

      ST_DONE: begin
        if (!out_vld_q || res_ready_i) begin
          out_vld_d = 1'b1;
          out_rd_d  = rs_rd_q;
          out_fp_d  = rs_fp_q;
          out_st_d  = rs_st_q;
          st_d      = ST_IDLE;
        end
      end

      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  assign res_valid_o          = out_vld_q;
  assign res_read_value_o     = out_rd_q;
  assign res_found_position_o = out_fp_q;
  assign res_status_o         = out_st_q;

  `ICLS_ASSERT_ALWAYS(len_within_cap, len_q <= LEN_W'(CAPACITY), "list length above capacity")
  `ICLS_ASSERT(no_write_when_idle, (st_q == ST_IDLE || st_q == ST_DONE) |-> !req_o.we,
               "store write outside command execution")
  `ICLS_ASSERT(shift_in_list, st_q == ST_SHIFT |-> (idx_ext + CMP_W'(1)) < len_ext,
               "delete shift reads past list end")
  `ICLS_ASSERT(found_implies_ok, (res_valid_o && res_found_position_o != 6'd0) |-> !res_status_o,
               "found position reported with missing status")

endmodule

[rtl/core/indexed_char_list_store_unit.sv]
// Channel | Dir | Fields                                   | Beat accepted
// cmd_i   | in  | command[2:0] position[6:0] char_value[7:0] | valid && ready
// res_o   | out | read_value[7:0] found_position[5:0] status | valid && ready
//
// Walks: delete shifts each later entry down a slot; find scans from index 0
//   to the first hit or the list end. Both go one entry per cycle, paced by the
//   store's single read port.
// Reset: list length is capacity and every entry reads as space; no clearing pass.
// Restart clears all the entry valid flags together.
// Stalls: one result beat is held in an output register, so the next command
//   is taken while it waits; a command finishes only once that register frees up.
module indexed_char_list_store_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  icls_cmd_if.sink   cmd_i,
  icls_res_if.source res_o
);
  import icls_pkg::*;

  store_req_t store_req;
  logic [7:0] store_rdata;

  // sequencer: decode, range checks, shift/scan walk, result register
  icls_seq u_seq (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_valid_i          (cmd_i.valid),
    .cmd_ready_o          (cmd_i.ready),
    .cmd_command_i        (cmd_i.command),
    .cmd_position_i       (cmd_i.position),
    .cmd_char_value_i     (cmd_i.char_value),
    .res_valid_o          (res_o.valid),
    .res_ready_i          (res_o.ready),
    .res_read_value_o     (res_o.read_value),
    .res_found_position_o (res_o.found_position),
    .res_status_o         (res_o.status),
    .req_o                (store_req),
    .rdata_i              (store_rdata)
  );

  // 64 x 8 character store, registered read, space for unwritten entries
  icls_store u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (store_req),
    .rdata_o (store_rdata)
  );

endmodule

[dv/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import icls_pkg::*;

  // Codes 5..7 carry no operation; the block must answer them with all zeros.
  localparam logic [2:0] CMD_SPARE_LO = 3'd5;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;

  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned TAIL_CYCLES = 100;   // longer than the slowest command

  typedef struct packed {
    logic [7:0] read_value;
    logic [5:0] found_position;
    logic       status;
  } list_answer_t;

  typedef struct {
    logic [2:0]   command;
    logic [6:0]   position;
    logic [7:0]   char_value;
    list_answer_t want;
  } pending_answer_t;

  logic clk_i;
  logic rst_ni;

  icls_cmd_if cmd_bus ();
  icls_res_if res_bus ();

  indexed_char_list_store_unit uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_bus),
    .res_o  (res_bus)
  );

  // Shadow copy of the list, updated as each command beat is accepted.
  logic [7:0]       char_mirror [CAPACITY];
  logic [LEN_W-1:0] length_mirror;

  pending_answer_t answers_due [$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_request;     // long receiver hold-off, picked up by the receiver
  int unsigned mismatch_count;
  int unsigned stray_count;
  int unsigned answers_checked;
  int unsigned commands_sent;
  int unsigned cmd_tally [8];
  int unsigned find_hits;

  // Clock: 4 ns period.
  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // Run limit: 3 ms, far longer than the slowest legal run.
  initial begin
    #3ms;
    $display("timeout: %0d answers still due", answers_due.size());
    $display("CHECK FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  task automatic fill_mirror_spaces();
    for (int i = 0; i < CAPACITY; i++) char_mirror[i] = SPACE_CHAR;
  endtask

  // Applies one command to the shadow list and returns the answer it must give.
  function automatic list_answer_t compute_answer(logic [2:0] cmd, logic [6:0] pos,
                                                  logic [7:0] val);
    list_answer_t ans;
    int           len;
    ans = '0;
    len = int'(length_mirror);
    case (cmd)
      CMD_READ: begin
        if (pos < len) ans.read_value = char_mirror[pos];
        else ans.status = 1'b1;
      end
      CMD_WRITE: begin
        if (pos < len) char_mirror[pos] = val;
        else ans.status = 1'b1;
      end
      CMD_DELETE: begin
        if (pos < len) begin
          // Later entries slide down; the slot past the new end keeps its byte.
          for (int i = int'(pos); i + 1 < len; i++) char_mirror[i] = char_mirror[i + 1];
          length_mirror = LEN_W'(len - 1);
        end else begin
          ans.status = 1'b1;
        end
      end
      CMD_FIND: begin
        // First match wins; a miss (or an empty list) reports status 1, index 0.
        ans.status = 1'b1;
        for (int i = 0; i < len; i++) begin
          if (ans.status && char_mirror[i] == val) begin
            ans.found_position = 6'(i);
            ans.status         = 1'b0;
          end
        end
      end
      CMD_RESTART: begin
        for (int i = 0; i < CAPACITY; i++) char_mirror[i] = SPACE_CHAR;
        length_mirror = (pos > CAPACITY) ? LEN_W'(CAPACITY) : LEN_W'(pos);
      end
      default: ;
    endcase
    return ans;
  endfunction

  // ---------------------------------------------------------------------------
  // Command driver: changes inputs at the falling edge, samples at the rising.
  // Entered and left just after a falling edge. valid stays up between
  // back-to-back beats, so it is never lowered and raised in one step.
  // ---------------------------------------------------------------------------

  task automatic send_command(logic [2:0] cmd, logic [6:0] pos, logic [7:0] val);
    pending_answer_t entry;
    bit              taken;
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_bus.valid = 1'b0;
      @(negedge clk_i);
    end
    cmd_bus.valid      = 1'b1;
    cmd_bus.command    = cmd;
    cmd_bus.position   = pos;
    cmd_bus.char_value = val;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk_i);
      if (cmd_bus.ready) begin
        taken = 1'b1;
      end else begin
        @(negedge clk_i);
      end
    end
    entry.command    = cmd;
    entry.position   = pos;
    entry.char_value = val;
    entry.want       = compute_answer(cmd, pos, val);
    if (cmd == CMD_FIND && !entry.want.status) find_hits++;
    answers_due.push_back(entry);
    commands_sent++;
    cmd_tally[cmd]++;
    @(negedge clk_i);
  endtask

  // Sender stops and waits until every outstanding answer has come back.
  task automatic wait_for_answers();
    cmd_bus.valid = 1'b0;
    while (answers_due.size() != 0) @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Answer receiver and checker
  // ---------------------------------------------------------------------------

  initial begin : answer_checker
    int unsigned     hold_left;
    pending_answer_t exp_entry;
    list_answer_t    got;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        res_bus.ready = 1'b0;
        hold_left--;
      end else begin
        res_bus.ready = ($urandom_range(99) >= recv_idle_pct);
      end
      @(posedge clk_i);
      if (rst_ni && res_bus.valid && res_bus.ready) begin
        got.read_value     = res_bus.read_value;
        got.found_position = res_bus.found_position;
        got.status         = res_bus.status;
        if (answers_due.size() == 0) begin
          stray_count++;
          if (mismatch_count + stray_count <= MAX_REPORTS)
            $display("unexpected answer beat: rd=%h fp=%0d st=%b",
                     got.read_value, got.found_position, got.status);
        end else begin
          exp_entry = answers_due.pop_front();
          answers_checked++;
          if (got.read_value !== exp_entry.want.read_value ||
              got.found_position !== exp_entry.want.found_position ||
              got.status !== exp_entry.want.status) begin
            mismatch_count++;
            if (mismatch_count + stray_count <= MAX_REPORTS)
              $display("mismatch cmd=%0d pos=%0d val=%h: exp rd=%h fp=%0d st=%b, got rd=%h fp=%0d st=%b",
                       exp_entry.command, exp_entry.position, exp_entry.char_value,
                       exp_entry.want.read_value, exp_entry.want.found_position,
                       exp_entry.want.status, got.read_value, got.found_position,
                       got.status);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Edges of the fields, every command, and the corner cases: out-of-range
  // index, empty list, failed search, oversize restart, spare codes, and
  // deletes at both ends of a nearly full list.
  task automatic test_directed();
    send_command(CMD_READ,    7'd0,   8'h00);   // fresh store reads as space
    send_command(CMD_READ,    7'd63,  8'hFF);
    send_command(CMD_READ,    7'd64,  8'h00);   // just past the end
    send_command(CMD_READ,    7'd127, 8'h00);
    send_command(CMD_FIND,    7'd0,   SPACE_CHAR);
    send_command(CMD_FIND,    7'd127, 8'h00);   // miss
    send_command(CMD_WRITE,   7'd0,   8'hFF);
    send_command(CMD_WRITE,   7'd63,  8'h00);
    send_command(CMD_WRITE,   7'd64,  8'h55);   // out of range, no effect
    send_command(CMD_READ,    7'd0,   8'h00);
    send_command(CMD_FIND,    7'd0,   8'h00);   // hit at the last slot
    send_command(CMD_DELETE,  7'd0,   8'h00);   // longest shift
    send_command(CMD_DELETE,  7'd62,  8'h00);   // removes the last entry
    send_command(CMD_DELETE,  7'd62,  8'h00);   // now past the end
    send_command(CMD_READ,    7'd62,  8'h00);   // vacated slot is not readable
    for (int c = CMD_SPARE_LO; c <= CMD_SPARE_HI; c++)
      send_command(3'(c), 7'h7F, 8'hFF);
    send_command(CMD_RESTART, 7'd127, 8'hFF);   // saturates to full capacity
    send_command(CMD_READ,    7'd63,  8'h00);
    send_command(CMD_RESTART, 7'd0,   8'h00);   // empty list
    send_command(CMD_FIND,    7'd0,   SPACE_CHAR);
    send_command(CMD_WRITE,   7'd0,   8'hAA);
    send_command(CMD_DELETE,  7'd0,   8'h00);
    send_command(CMD_RESTART, 7'd1,   8'h00);
    send_command(CMD_WRITE,   7'd0,   8'hAA);
    send_command(CMD_DELETE,  7'd0,   8'h00);   // back to empty
    send_command(CMD_RESTART, 7'd64,  8'h00);
  endtask

  // Mostly legal commands aimed inside the list, with find keys drawn from
  // the list contents so hits land at varied depths; the rest is noise.
  task automatic send_random_commands(int unsigned count);
    logic [2:0]  cmd;
    logic [6:0]  pos;
    logic [7:0]  val;
    int unsigned pick;
    int unsigned len;
    for (int unsigned n = 0; n < count; n++) begin
      len  = length_mirror;
      pick = $urandom_range(99);
      val  = 8'($urandom);
      if (pick < 20)      cmd = CMD_READ;
      else if (pick < 45) cmd = CMD_WRITE;
      else if (pick < 60) cmd = CMD_DELETE;
      else if (pick < 85) cmd = CMD_FIND;
      else if (pick < 91) cmd = CMD_RESTART;
      else if (pick < 95) cmd = 3'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO));
      else                cmd = 3'($urandom_range(CMD_FIND, CMD_READ));
      if (len != 0 && pick < 95 && $urandom_range(99) < 85)
        pos = 7'($urandom_range(len - 1));
      else
        pos = 7'($urandom);
      if (cmd == CMD_FIND && $urandom_range(99) < 70)
        val = char_mirror[$urandom_range(CAPACITY - 1)];
      if (cmd == CMD_RESTART) begin
        case ($urandom_range(4))
          0, 1:    pos = 7'(CAPACITY);
          2:       pos = 7'($urandom_range(4));
          default: pos = 7'($urandom);
        endcase
      end
      send_command(cmd, pos, val);
    end
  endtask

  task automatic test_random_slow_sender();
    send_idle_pct = 38;
    recv_idle_pct = 73;
    send_random_commands(350);
  endtask

  task automatic test_random_slow_receiver();
    send_idle_pct = 73;
    recv_idle_pct = 38;
    send_random_commands(350);
  endtask

  // Receiver stalls for a long stretch while the sender keeps offering beats:
  // the output register fills and the block must back-pressure its input.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int round = 0; round < 2; round++) begin
      hold_request = 250;
      send_random_commands(12);
      wait_for_answers();
    end
  endtask

  task automatic test_random_full_rate();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random_commands(350);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin : run_tests
    rst_ni             = 1'b0;
    cmd_bus.valid      = 1'b0;
    cmd_bus.command    = CMD_READ;
    cmd_bus.position   = '0;
    cmd_bus.char_value = '0;
    res_bus.ready      = 1'b0;
    send_idle_pct      = 38;
    recv_idle_pct      = 73;
    hold_request       = 0;
    mismatch_count     = 0;
    stray_count        = 0;
    answers_checked    = 0;
    commands_sent      = 0;
    find_hits          = 0;
    foreach (cmd_tally[i]) cmd_tally[i] = 0;
    fill_mirror_spaces();
    length_mirror = LEN_W'(CAPACITY);

    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    test_random_slow_sender();
    test_random_slow_receiver();
    test_backpressure();
    test_random_full_rate();

    wait_for_answers();
    repeat (TAIL_CYCLES) @(negedge clk_i);

    $display("ran %0d commands (rd %0d wr %0d del %0d find %0d restart %0d spare %0d), %0d finds hit",
             commands_sent, cmd_tally[CMD_READ], cmd_tally[CMD_WRITE], cmd_tally[CMD_DELETE],
             cmd_tally[CMD_FIND], cmd_tally[CMD_RESTART],
             cmd_tally[5] + cmd_tally[6] + cmd_tally[7], find_hits);
    $display("checked %0d answers under sender/receiver stalls and long back-pressure",
             answers_checked);
    if (mismatch_count == 0 && stray_count == 0 && answers_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches, %0d stray beats, %0d answers missing",
               mismatch_count, stray_count, answers_due.size());
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
